### src/npc_pkg.sv
// Shared types, constants and distance arithmetic for the nearest palette color core.
package npc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int KEY_W = (CNT_W > 9) ? CNT_W : 9;

    localparam int CH_W   = 8;
    localparam int RGB_W  = 3 * CH_W;
    localparam int DIST_W = 10;
    localparam int SIZE_W = 9;
    localparam int IDX_W  = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // query token passed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [RGB_W-1:0]    pixel;
        logic [RGB_W-1:0]    best;
        logic [DIST_W-1:0]   dist_sum;
    } t_token;

    // palette write broadcast to every cell
    typedef struct packed {
        logic                en;
        logic [KEY_W-1:0]    key;
        logic [RGB_W-1:0]    rgb;
    } t_load;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // rgb packed red high, blue low
    function automatic logic [DIST_W-1:0] manhattan(input logic [RGB_W-1:0] a,
                                                    input logic [RGB_W-1:0] b);
        manhattan = DIST_W'(abs_diff(a[23:16], b[23:16]))
                  + DIST_W'(abs_diff(a[15:8], b[15:8]))
                  + DIST_W'(abs_diff(a[7:0], b[7:0]));
    endfunction

endpackage

### src/npc_cell.sv
// One palette cell: holds an entry and updates the passing query's best match.
module npc_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [npc_pkg::KEY_W-1:0] i_index,
    input  logic [npc_pkg::KEY_W-1:0] i_count,
    input  npc_pkg::t_load         i_load,
    input  npc_pkg::t_token        i_tok,
    output npc_pkg::t_token        o_tok
);

    logic [npc_pkg::RGB_W-1:0]  r_entry;
    logic                       r_valid;
    logic [npc_pkg::RGB_W-1:0]  r_pixel;
    logic [npc_pkg::RGB_W-1:0]  r_best;
    logic [npc_pkg::DIST_W-1:0] r_dist;

    logic [npc_pkg::DIST_W-1:0] w_dist;
    logic                       w_take;

    always_comb begin
        w_dist = npc_pkg::manhattan(r_entry, i_tok.pixel);
        // first cell seeds the search; later cells win only on strictly smaller distance
        w_take = (i_index == '0) || ((i_index < i_count) && (w_dist < i_tok.dist_sum));
    end

    always_ff @(posedge i_clk) begin
        if (i_load.en && (i_load.key == i_index)) begin
            r_entry <= i_load.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= i_tok.pixel;
        r_best  <= w_take ? r_entry : i_tok.best;
        r_dist  <= w_take ? w_dist  : i_tok.dist_sum;
    end

    assign o_tok = '{valid: r_valid, pixel: r_pixel, best: r_best, dist_sum: r_dist};

endmodule

### src/nearest_palette_color_core.sv
// Top level: nearest palette color search over a systolic row of palette cells.
//
//  channel  | dir | handshake               | payload (low bit up)
//  ---------+-----+-------------------------+----------------------------------------------
//  s_axis   | in  | s_axis_tvalid / tready  | tdata: entry_index, red, green, blue; tuser: kind
//  m_axis   | out | m_axis_tvalid / tready  | tdata: nearest_red, nearest_green, nearest_blue,
//           |     |                         |        distance, zero pad
//  cfg      | in  | i_cfg_valid / o_cfg_ready | i_cfg_data: palette_size
//
// A load item writes the cell whose index matches.
// A query item enters cell 0 at acceptance and walks the row one cell per cycle; the
// output register takes the last cell's token. s_axis reopens as that result is
// registered, so a new query starts only after the previous one has left the row.
// While a result waits in the output register a new query may start; a second
// finished result parks in a hold register, and s_axis stalls until it drains.
// Reset clears handshake state and sets palette_size to 1; palette contents are
// undefined until loaded.
module nearest_palette_color_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0] s_axis_tdata,
    // kind[0]
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // nearest_red[7:0], nearest_green[15:8], nearest_blue[23:16], distance[33:24], pad
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // palette_size[8:0]
    input  logic [8:0]  i_cfg_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready
);

    localparam int DEPTH = npc_pkg::PALETTE_DEPTH;
    localparam int KW    = npc_pkg::KEY_W;

    // ---------------- configuration ----------------
    logic [KW-1:0] r_count;   // saturated to 1..DEPTH
    logic [KW-1:0] w_size;

    assign o_cfg_ready = 1'b1;
    assign w_size      = KW'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= KW'(1);
        end else if (i_cfg_valid) begin
            if (w_size == '0) begin
                r_count <= KW'(1);
            end else if (w_size > KW'(DEPTH)) begin
                r_count <= KW'(DEPTH);
            end else begin
                r_count <= w_size;
            end
        end
    end

    // ---------------- input decode ----------------
    logic                        w_in_fire;
    logic                        w_query;
    logic [npc_pkg::RGB_W-1:0]   w_rgb;
    npc_pkg::t_load              w_load;
    npc_pkg::t_token             w_tok [0:DEPTH];

    logic r_busy;     // a query is walking the row
    logic r_hold_v;   // second result parked behind the output register

    assign s_axis_tready = !r_busy && !r_hold_v;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_query       = (s_axis_tuser[0] == npc_pkg::KIND_QUERY);
    // palette word: red high, blue low
    assign w_rgb         = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};

    assign w_load = '{en:  w_in_fire && (s_axis_tuser[0] == npc_pkg::KIND_LOAD),
                      key: KW'(s_axis_tdata[7:0]),
                      rgb: w_rgb};

    assign w_tok[0] = '{valid: w_in_fire && w_query, pixel: w_rgb,
                        best: '0, dist_sum: '0};

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        npc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (KW'(g)),
            .i_count (r_count),
            .i_load  (w_load),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // ---------------- result path ----------------
    npc_pkg::t_token w_exit;
    logic            r_out_v;
    logic [33:0]     r_out;
    logic [33:0]     r_hold;
    logic [33:0]     w_res;
    logic            w_out_free;

    assign w_exit     = w_tok[DEPTH];
    assign w_res      = {w_exit.dist_sum, w_exit.best[7:0], w_exit.best[15:8],
                         w_exit.best[23:16]};
    assign w_out_free = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (w_in_fire && w_query) begin
                r_busy <= 1'b1;
            end else if (w_exit.valid) begin
                r_busy <= 1'b0;
            end
            if (w_out_free) begin
                if (r_hold_v) begin
                    r_out_v  <= 1'b1;
                    r_hold_v <= 1'b0;
                end else begin
                    r_out_v <= w_exit.valid;
                end
            end else if (w_exit.valid) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_hold_v ? r_hold : w_res;
        end
        if (!w_out_free && w_exit.valid) begin
            r_hold <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'd0, r_out};

    // ---------------- assertions ----------------
    logic [DEPTH:0] w_tok_valids;
    for (genvar v = 0; v <= DEPTH; v++) begin : g_vbits
        assign w_tok_valids[v] = w_tok[v].valid;
    end

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valids))
        else $error("more than one query in the cell row");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_busy)
        else $error("result left the row with no query in flight");

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("hold register full while output register empty");

    a_exit_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> !r_hold_v)
        else $error("result arrived while hold register occupied");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_query) |=> (r_busy && !s_axis_tready))
        else $error("query accepted but row not marked busy");

endmodule

### sim/nearest_palette_color_core_tb.sv
// Self-checking testbench for nearest_palette_color_core: table of directed items, then random phases.
module nearest_palette_color_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    // settle time covers a query's walk through every cell and the output register
    localparam int SETTLE_CYCLES = PALETTE_DEPTH + 8;
    localparam int PHASE_ITEMS   = 180;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] dist_sum;
    } t_hit;

    // one stimulus row: either a palette_size write or an s_axis item
    typedef struct packed {
        logic       is_cfg;
        logic [8:0] size;
        logic       kind;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fixed;    // want holds a hand-typed result
        t_hit       want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [8:0]  i_cfg_data    = '0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;

    // travels alongside the item so the checker knows a typed result is attached
    logic        fixed_valid   = 1'b0;
    t_hit        fixed_hit     = '0;

    // mirror of the palette and size register, updated at acceptance
    logic [23:0] pal_copy [PALETTE_DEPTH];
    logic [8:0]  size_copy = 9'd1;
    t_hit        pending_hits [$];

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned error_count = 0;

    t_row        dir_rows [$];

    nearest_palette_color_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_data    (i_cfg_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("nearest_palette_color_core_tb: FAIL");
        $finish;
    end

    // receiver backpressure, one decision per cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // number of entries actually searched: 0 acts as 1, above depth saturates
    function automatic int search_span(input logic [8:0] size);
        if (size == 0)
            return 1;
        if (size > PALETTE_DEPTH)
            return PALETTE_DEPTH;
        return int'(size);
    endfunction

    function automatic int chan_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Manhattan search over the mirrored palette; strict < keeps the lowest index on ties
    function automatic t_hit nearest_of(input logic [23:0] px);
        t_hit hit;
        int   span;
        int   d;
        span = search_span(size_copy);
        hit.red      = pal_copy[0][23:16];
        hit.green    = pal_copy[0][15:8];
        hit.blue     = pal_copy[0][7:0];
        hit.dist_sum = 10'(chan_gap(hit.red, px[23:16]) + chan_gap(hit.green, px[15:8])
                         + chan_gap(hit.blue, px[7:0]));
        for (int k = 1; k < span; k++) begin
            d = chan_gap(pal_copy[k][23:16], px[23:16]) + chan_gap(pal_copy[k][15:8], px[15:8])
              + chan_gap(pal_copy[k][7:0], px[7:0]);
            if (d < int'(hit.dist_sum)) begin
                hit.red      = pal_copy[k][23:16];
                hit.green    = pal_copy[k][15:8];
                hit.blue     = pal_copy[k][7:0];
                hit.dist_sum = 10'(d);
            end
        end
        return hit;
    endfunction

    // acceptance tracking, prediction and checking all sample pre-edge values here
    always @(posedge i_clk) begin
        t_hit want;
        t_hit got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                size_copy = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == KIND_LOAD)
                    pal_copy[s_axis_tdata[7:0]] = {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                                   s_axis_tdata[31:24]};
                else if (fixed_valid)
                    pending_hits.push_back(fixed_hit);
                else
                    pending_hits.push_back(nearest_of({s_axis_tdata[15:8], s_axis_tdata[23:16],
                                                       s_axis_tdata[31:24]}));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.red      = m_axis_tdata[7:0];
                got.green    = m_axis_tdata[15:8];
                got.blue     = m_axis_tdata[23:16];
                got.dist_sum = m_axis_tdata[33:24];
                if (pending_hits.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result rgb=%02h%02h%02h dist=%0d",
                                 $realtime, got.red, got.green, got.blue, got.dist_sum);
                end else begin
                    want = pending_hits.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch exp %02h%02h%02h/%0d got %02h%02h%02h/%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     want.dist_sum, got.red, got.green, got.blue,
                                     got.dist_sum);
                    end
                end
            end
        end
    end

    function automatic t_row cfg_row(input logic [8:0] size);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.size   = size;
        return row;
    endfunction

    function automatic t_row item_row(input logic kind, input logic [7:0] idx,
                                      input logic [23:0] rgb);
        t_row row;
        row = '0;
        row.kind = kind;
        row.idx  = idx;
        {row.red, row.green, row.blue} = rgb;
        return row;
    endfunction

    function automatic t_row typed_query(input logic [7:0] idx, input logic [23:0] rgb,
                                         input logic [23:0] near_rgb,
                                         input logic [9:0] near_dist);
        t_row row;
        row = item_row(KIND_QUERY, idx, rgb);
        row.fixed = 1'b1;
        {row.want.red, row.want.green, row.want.blue} = near_rgb;
        row.want.dist_sum = near_dist;
        return row;
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] ch);
        int v;
        v = int'(ch) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Mostly well-formed traffic: loads into the searched range and queries close to
    // stored colors (small distances, ties), plus uniform noise on both.
    function automatic t_row random_item(input int span);
        t_row row;
        int   e;
        row = item_row(KIND_LOAD, 8'($urandom_range(255)), 24'($urandom));
        if ($urandom_range(99) < 40) begin
            row.kind = KIND_QUERY;
            if ($urandom_range(1) == 1) begin
                e = $urandom_range(span - 1);
                row.red   = nudge(pal_copy[e][23:16]);
                row.green = nudge(pal_copy[e][15:8]);
                row.blue  = nudge(pal_copy[e][7:0]);
            end
        end else begin
            if ($urandom_range(1) == 1)
                row.idx = 8'($urandom_range(span - 1));
            // duplicate an existing color now and then to force exact ties
            if ($urandom_range(3) == 0) begin
                e = $urandom_range(PALETTE_DEPTH - 1);
                {row.red, row.green, row.blue} = pal_copy[e];
            end
        end
        return row;
    endfunction

    // drives one item and waits for s_axis_tready; tvalid stays high if no gap is drawn
    task automatic send_item(input t_row row);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.blue, row.green, row.red, row.idx};
        s_axis_tuser  <= row.kind;
        fixed_valid   <= row.fixed;
        fixed_hit     <= row.want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender holds off until every outstanding result is back and the row has settled
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_palette_size(input logic [8:0] size);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase_sizes [8];
        int          span;

        for (int k = 0; k < PALETTE_DEPTH; k++)
            pal_copy[k] = '0;

        // directed rows; palette_size is 1 out of reset
        dir_rows.push_back(item_row(KIND_LOAD, 8'd0, 24'h000000));
        dir_rows.push_back(typed_query(8'd0, 24'hFFFFFF, 24'h000000, 10'd765));
        dir_rows.push_back(typed_query(8'd255, 24'h000000, 24'h000000, 10'd0)); // index ignored
        dir_rows.push_back(item_row(KIND_LOAD, 8'd0, 24'hFFFFFF));
        dir_rows.push_back(typed_query(8'd0, 24'h000000, 24'hFFFFFF, 10'd765));
        dir_rows.push_back(typed_query(8'd0, 24'hFFFFFF, 24'hFFFFFF, 10'd0));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd255, 24'hFF00FF));
        // zero size still searches entry 0 only
        dir_rows.push_back(cfg_row(9'd0));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd1, 24'h000000));
        dir_rows.push_back(typed_query(8'd0, 24'h000000, 24'hFFFFFF, 10'd765));
        dir_rows.push_back(cfg_row(9'd2));
        dir_rows.push_back(typed_query(8'd0, 24'h000000, 24'h000000, 10'd0));
        // three entries equally close to black: lowest index wins
        dir_rows.push_back(cfg_row(9'd3));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd0, 24'h010000));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd1, 24'h000100));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd2, 24'h000001));
        dir_rows.push_back(typed_query(8'd0, 24'h000000, 24'h010000, 10'd1));
        dir_rows.push_back(item_row(KIND_QUERY, 8'd0, 24'h000101));
        dir_rows.push_back(item_row(KIND_QUERY, 8'd0, 24'h807F01));
        dir_rows.push_back(item_row(KIND_LOAD, 8'd1, 24'h102030));
        dir_rows.push_back(item_row(KIND_QUERY, 8'd0, 24'h112233));

        phase_sizes = '{256, 1, 511, 0, 5, 255, 2, $urandom_range(3, 40)};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                set_palette_size(dir_rows[r].size);
            else
                send_item(dir_rows[r]);
        end
        drain_results();

        // every entry written once, so any later search range is safe
        for (int k = 0; k < PALETTE_DEPTH; k++)
            send_item(item_row(KIND_LOAD, 8'(k), 24'($urandom)));

        // phases cycle through: no idling, sender gaps, receiver stalls, both
        foreach (phase_sizes[p]) begin
            set_palette_size(9'(phase_sizes[p]));
            span = search_span(9'(phase_sizes[p]));
            case (p % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 69;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 69;
                end
                default: begin
                    gap_pct = 15;
                    stall_pct = 15;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(random_item(span));
        end

        drain_results();
        if (pending_hits.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("nearest_palette_color_core_tb: PASS");
        else
            $display("nearest_palette_color_core_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
src/npc_pkg.sv
src/npc_cell.sv
src/nearest_palette_color_core.sv
sim/nearest_palette_color_core_tb.sv
